FILE: sv/ssgr_pkg.sv
`timescale 1ns / 1ps
package ssgr_pkg;

	localparam int BATCHES   = 16;
	localparam int NEURONS   = 512;
	localparam int MAX_DENSE = 64;

	localparam int B_W    = 4;
	localparam int N_W    = 9;
	localparam int ADDR_W = B_W + N_W;
	localparam int DEPTH  = BATCHES * NEURONS;
	localparam int TIME_W = 33;  // signed channel time, -1 after clear
	localparam int VAL_W  = 8;
	localparam int WORD_W = TIME_W + VAL_W;

	localparam int NUM_W = 51;  // 2*256*(v*(d-x)+s*x) + d
	localparam int DEN_W = 34;  // 2*d
	localparam int QUO_W = 17;

	localparam logic [1:0] REG_INTERP_MODE = 2'd0;
	localparam logic [1:0] REG_SPARSE_STEP = 2'd1;
	localparam logic [1:0] REG_DENSE_STEP  = 2'd2;
	localparam logic [1:0] REG_DENSE_LEN   = 2'd3;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_READ  = 8'b0000_0010,
		ST_SCAN  = 8'b0000_0100,
		ST_MUL   = 8'b0000_1000,
		ST_DIVS  = 8'b0001_0000,
		ST_DIVW  = 8'b0010_0000,
		ST_OUT   = 8'b0100_0000,
		ST_WRITE = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage

FILE: sv/ssgr_chan_mem.sv
`timescale 1ns / 1ps
module ssgr_chan_mem import ssgr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          req,
	output logic [WORD_W-1:0] rdata,
	output logic              busy
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic              busy_q;

	// clear pass: one entry per cycle, time -1 and value 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ADDR_W'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= {{TIME_W{1'b1}}, {VAL_W{1'b0}}};
		end else if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

	assign busy = busy_q;

endmodule

FILE: sv/ssgr_divider.sv
`timescale 1ns / 1ps
module ssgr_divider import ssgr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [QUO_W-1:0] quot
);

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= NUM_W'({req.den, {(QUO_W-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: sv/sparse_sample_grid_resampler_unit.sv
`timescale 1ns / 1ps
// channel  | dir | handshake          | word contents (low bit first)
// s_*      | in  | s_tvalid/s_tready  | tdata: batch, neuron, time_index, sample_value
//          |     |                    | tuser: opcode (0 sample, 1 finish)
// m_*      | out | m_tvalid/m_tready  | tdata: batch, neuron, dense_step, dense_value
//          |     |                    | tlast: last point caused by the input word
// cfg_*    | in  | cfg_we             | index 0 mode, 1 sparse step, 2 dense step, 3 length
//
// After reset the channel store is swept over all 8192 entries with s_tready low.
// An input word passes through the read, scan and write states, with one scan step per grid
// index skipped and one closing scan step when no point ends it; each emitted point goes
// through the output state alone (nearest neighbor, finish) or first through an 8x32 and an
// 8x33 product, then the 17-bit divider and its done state (linear).
// A stalled m_tready holds the sequencer only when a new point is ready.
module sparse_sample_grid_resampler_unit import ssgr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // batch[3:0], neuron[12:4], time_index[28:13], sample[36:29]
	input  logic [0:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // batch[3:0], neuron[12:4], step[18:13], value[34:19]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	state_t state_q;

	// configuration
	logic        mode_q;
	logic [15:0] sst_q;
	logic [15:0] dt_q;    // zero maps to one
	logic [6:0]  len_q;   // saturated to MAX_DENSE

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			sst_q  <= 16'd1;
			dt_q   <= 16'd1;
			len_q  <= 7'(MAX_DENSE);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERP_MODE: mode_q <= cfg_data[0];
				REG_SPARSE_STEP: sst_q <= cfg_data;
				REG_DENSE_STEP:  dt_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
				REG_DENSE_LEN:   len_q <= (cfg_data[6:0] > 7'(MAX_DENSE)) ?
					7'(MAX_DENSE) : cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// item registers
	logic                     op_q;
	logic [B_W-1:0]           b_q;
	logic [N_W-1:0]           n_q;
	logic [15:0]              ts_q;
	logic [7:0]               s_q;
	logic signed [TIME_W-1:0] p_q;
	logic [7:0]               v_q;
	logic [31:0]              tt_q;
	logic [6:0]               t_q;
	logic [21:0]              g_q;    // t * dt
	logic [15:0]              val_q;
	logic                     last_q;
	logic [40:0]              pa_q;
	logic [40:0]              pb_q;

	mem_req_t          mreq;
	logic [WORD_W-1:0] mrdata;
	logic              mbusy;
	div_req_t          dreq;
	logic              ddone;
	logic [QUO_W-1:0]  dquot;

	ssgr_chan_mem u_mem (.clk, .arst_n, .req(mreq), .rdata(mrdata), .busy(mbusy));
	ssgr_divider  u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quot(dquot));

	// scan of the current grid index
	logic [TIME_W-1:0] g_ext;
	logic              ge_p, lt_tt, hit, last_n;
	logic [21:0]       gn;
	logic [TIME_W-1:0] x;
	logic [31:0]       to_cur;
	logic [TIME_W-1:0] d;
	logic [41:0]       sum;
	logic              s_acc, out_ld;

	assign g_ext  = TIME_W'(g_q);
	assign ge_p   = $signed(g_ext) >= p_q;
	assign lt_tt  = 32'(g_q) < tt_q;
	assign gn     = g_q + 22'(dt_q);
	assign hit    = ge_p && (op_q == OP_FINISH || lt_tt);
	assign last_n = (t_q + 7'd1 == len_q) || (op_q == OP_SAMPLE && 32'(gn) >= tt_q);
	assign x      = g_ext - p_q;
	assign to_cur = tt_q - 32'(g_q);
	assign d      = {1'b0, tt_q} - p_q;
	assign sum    = 42'(pa_q) + 42'(pb_q);

	assign s_acc  = s_tvalid && s_tready;
	assign out_ld = (state_q == ST_OUT) && (!m_tvalid || m_tready);

	always_comb begin
		mreq.we    = (state_q == ST_WRITE);
		mreq.waddr = {b_q, n_q};
		mreq.wdata = (op_q == OP_FINISH) ? {{TIME_W{1'b1}}, {VAL_W{1'b0}}} :
			{1'b0, tt_q, s_q};
		mreq.raddr = {s_tdata[3:0], s_tdata[12:4]};
		dreq.start = (state_q == ST_DIVS);
		dreq.num   = {sum, 9'b0} + NUM_W'(d);
		dreq.den   = {d, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (s_acc) state_q <= ST_READ;
				ST_READ:  state_q <= ST_SCAN;
				ST_SCAN: begin
					if (t_q >= len_q) begin
						state_q <= ST_WRITE;
					end else if (hit) begin
						state_q <= (op_q == OP_FINISH || mode_q) ? ST_OUT : ST_MUL;
					end else if (op_q == OP_SAMPLE && !lt_tt) begin
						state_q <= ST_WRITE;
					end
				end
				ST_MUL:   state_q <= ST_DIVS;
				ST_DIVS:  state_q <= ST_DIVW;
				ST_DIVW:  if (ddone) state_q <= ST_OUT;
				ST_OUT:   if (out_ld) state_q <= last_q ? ST_WRITE : ST_SCAN;
				ST_WRITE: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q <= s_tuser[0];
			b_q  <= s_tdata[3:0];
			n_q  <= s_tdata[12:4];
			ts_q <= s_tdata[28:13];
			s_q  <= s_tdata[36:29];
		end
		if (state_q == ST_READ) begin
			p_q  <= $signed(mrdata[WORD_W-1:VAL_W]);
			v_q  <= mrdata[VAL_W-1:0];
			tt_q <= ts_q * sst_q;
			t_q  <= '0;
			g_q  <= '0;
		end
		if (state_q == ST_SCAN && t_q < len_q) begin
			if (hit) begin
				last_q <= last_n;
				if (op_q == OP_FINISH) begin
					val_q <= {v_q, 8'd0};
				end else begin
					val_q <= {(x < TIME_W'(to_cur)) ? v_q : s_q, 8'd0};
				end
			end else begin
				t_q <= t_q + 7'd1;
				g_q <= gn;
			end
		end
		if (state_q == ST_MUL) begin
			pa_q <= 41'(v_q * to_cur);
			pb_q <= 41'(s_q * x);
		end
		if (state_q == ST_DIVW && ddone) begin
			val_q <= dquot[15:0];
		end
		if (out_ld && !last_q) begin
			t_q <= t_q + 7'd1;
			g_q <= gn;
		end
	end

	// output register
	logic [3:0]  ob_q;
	logic [8:0]  on_q;
	logic [5:0]  ot_q;
	logic [15:0] ov_q;
	logic        ol_q;
	logic        ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_ld) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			ob_q <= b_q;
			on_q <= n_q;
			ot_q <= t_q[5:0];
			ov_q <= val_q;
			ol_q <= last_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !mbusy;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {5'd0, ov_q, ot_q, on_q, ob_q};
	assign m_tlast  = ol_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mbusy |-> !s_tready) else $error("input taken during clear pass");
	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> state_q == ST_READ) else $error("accept did not start a read");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		ddone |-> state_q == ST_DIVW) else $error("divider result outside wait");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |-> t_q < len_q) else $error("grid index beyond length");

endmodule
